### design/json_byte_tokenizer_assert.svh
// Assertion macros used by the checks in the top level of this block.
`ifndef JSON_BYTE_TOKENIZER_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define JBT_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define JBT_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### design/jbt_pkg.sv
package jbt_pkg;

    // Token type codes.
    localparam logic [3:0] TT_EOF       = 4'd0;
    localparam logic [3:0] TT_OBJ_OPEN  = 4'd1;
    localparam logic [3:0] TT_OBJ_CLOSE = 4'd2;
    localparam logic [3:0] TT_ARR_OPEN  = 4'd3;
    localparam logic [3:0] TT_ARR_CLOSE = 4'd4;
    localparam logic [3:0] TT_COLON     = 4'd5;
    localparam logic [3:0] TT_STRING    = 4'd6;
    localparam logic [3:0] TT_COMMA     = 4'd7;
    localparam logic [3:0] TT_KEYWORD   = 4'd8;
    localparam logic [3:0] TT_NUMBER    = 4'd9;

    // Lexer mode codes.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_STR     = 3'd1;
    localparam logic [2:0] MODE_STR_ESC = 3'd2;
    localparam logic [2:0] MODE_NUM     = 3'd3;
    localparam logic [2:0] MODE_KEY     = 3'd4;
    localparam logic [2:0] MODE_FAIL    = 3'd5;

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One result word as it leaves the block.
    typedef struct packed {
        logic [3:0] token_type;
        logic       has_char;
        logic [7:0] char_value;
        logic       token_end;
        logic       error;
        logic       last;
    } res_t;

    // Work handed from the front end to the back end: one or two results.
    typedef struct packed {
        logic two;
        res_t first;
        res_t second;
    } cmd_t;

    // Front end status seen by the top level checks.
    typedef struct packed {
        logic [2:0] mode;
        logic       push;
    } front_stat_t;

endpackage

### design/jbt_if.sv
// Input channel: one text byte or an end-of-input mark per word.
interface jbt_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// Output channel: one token event per word.
interface jbt_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_type;
    logic       has_char;
    logic [7:0] char_value;
    logic       token_end;
    logic       error;
    logic       last;

    modport source (output valid, output token_type, output has_char, output char_value,
                    output token_end, output error, output last, input ready);
    modport sink (input valid, input token_type, input has_char, input char_value,
                  input token_end, input error, input last, output ready);
endinterface

### design/jbt_front.sv
module jbt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    jbt_in_if.sink               bytes,
    input  logic                 push_ready,
    output logic                 push_valid,
    output jbt_pkg::cmd_t        push_cmd,
    output jbt_pkg::front_stat_t stat
);
    import jbt_pkg::*;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef struct packed {
        logic       emit;
        res_t       res;
        logic [2:0] mode;
    } idle_t;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    logic       accept;
    logic       eoi;
    logic [7:0] c;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    idle_t      ib;

    // Build one result word; the character is zero unless it is carried.
    function automatic res_t mk(input logic [3:0] tt, input logic has, input logic [7:0] ch,
                                input logic fin, input logic err);
        res_t r;
        r.token_type = tt;
        r.has_char   = has;
        r.char_value = has ? ch : 8'd0;
        r.token_end  = fin;
        r.error      = err;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] ch);
        return (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= 8'd48 && ch <= 8'd57;
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= 8'd65 && ch <= 8'd90) || (ch >= 8'd97 && ch <= 8'd122);
    endfunction

    // Classify a byte seen between tokens.
    function automatic idle_t idle_step(input logic [7:0] ch);
        idle_t t;
        t.emit = 1'b1;
        t.mode = MODE_IDLE;
        t.res  = mk(TT_EOF, 1'b0, 8'd0, 1'b0, 1'b0);
        case (ch)
            CH_LBRACE:   t.res = mk(TT_OBJ_OPEN, 1'b0, 8'd0, 1'b1, 1'b0);
            CH_RBRACE:   t.res = mk(TT_OBJ_CLOSE, 1'b0, 8'd0, 1'b1, 1'b0);
            CH_LBRACKET: t.res = mk(TT_ARR_OPEN, 1'b0, 8'd0, 1'b1, 1'b0);
            CH_RBRACKET: t.res = mk(TT_ARR_CLOSE, 1'b0, 8'd0, 1'b1, 1'b0);
            CH_COLON:    t.res = mk(TT_COLON, 1'b0, 8'd0, 1'b1, 1'b0);
            CH_COMMA:    t.res = mk(TT_COMMA, 1'b0, 8'd0, 1'b1, 1'b0);
            CH_QUOTE:
            begin
                t.emit = 1'b0;
                t.mode = MODE_STR;
            end
            default:
            begin
                if (is_ws(ch))
                begin
                    t.emit = 1'b0;
                end
                else if (is_digit(ch))
                begin
                    t.mode = MODE_NUM;
                    t.res  = mk(TT_NUMBER, 1'b1, ch, 1'b0, 1'b0);
                end
                else if (is_alpha(ch))
                begin
                    t.mode = MODE_KEY;
                    t.res  = mk(TT_KEYWORD, 1'b1, ch, 1'b0, 1'b0);
                end
                else
                begin
                    t.mode = MODE_FAIL;
                    t.res  = mk(TT_EOF, 1'b0, 8'd0, 1'b0, 1'b1);
                end
            end
        endcase
        return t;
    endfunction

    // The front end takes a word whenever the queue has room.
    assign bytes.ready = push_ready;
    assign accept      = bytes.valid && push_ready;
    assign eoi         = bytes.kind;
    assign c           = bytes.data_byte;
    assign ib          = idle_step(c);

    // Mode update and result words for the current input word.
    always_comb
    begin
        mode_next = mode_reg;
        n         = 2'd0;
        r0        = mk(TT_EOF, 1'b0, 8'd0, 1'b0, 1'b0);
        r1        = mk(TT_EOF, 1'b0, 8'd0, 1'b0, 1'b0);
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (eoi)
                begin
                    r0 = mk(TT_EOF, 1'b0, 8'd0, 1'b1, 1'b0);
                    n  = 2'd1;
                end
                else
                begin
                    r0        = ib.res;
                    n         = {1'b0, ib.emit};
                    mode_next = ib.mode;
                end
            end
            MODE_STR, MODE_STR_ESC:
            begin
                if (eoi)
                begin
                    r0        = mk(TT_STRING, 1'b0, 8'd0, 1'b1, 1'b0);
                    r1        = mk(TT_EOF, 1'b0, 8'd0, 1'b1, 1'b0);
                    n         = 2'd2;
                    mode_next = MODE_IDLE;
                end
                else if (mode_reg == MODE_STR && c == CH_QUOTE)
                begin
                    r0        = mk(TT_STRING, 1'b0, 8'd0, 1'b1, 1'b0);
                    n         = 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (mode_reg == MODE_STR && c == CH_BACKSLASH)
                begin
                    mode_next = MODE_STR_ESC;
                end
                else
                begin
                    r0        = mk(TT_STRING, 1'b1, c, 1'b0, 1'b0);
                    n         = 2'd1;
                    mode_next = MODE_STR;
                end
            end
            MODE_NUM, MODE_KEY:
            begin
                if (!eoi && ((mode_reg == MODE_NUM) ? is_digit(c) : is_alpha(c)))
                begin
                    r0 = mk((mode_reg == MODE_NUM) ? TT_NUMBER : TT_KEYWORD,
                            1'b1, c, 1'b0, 1'b0);
                    n  = 2'd1;
                end
                else
                begin
                    // Close the run, then treat the byte as if between tokens.
                    r0 = mk((mode_reg == MODE_NUM) ? TT_NUMBER : TT_KEYWORD,
                            1'b0, 8'd0, 1'b1, 1'b0);
                    if (eoi)
                    begin
                        r1        = mk(TT_EOF, 1'b0, 8'd0, 1'b1, 1'b0);
                        n         = 2'd2;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        r1        = ib.res;
                        n         = ib.emit ? 2'd2 : 2'd1;
                        mode_next = ib.mode;
                    end
                end
            end
            MODE_FAIL:
            begin
                mode_next = MODE_FAIL;
            end
            default:
            begin
                mode_next = MODE_FAIL;
            end
        endcase

        // Mark the final result of this word.
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
        else if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
    end

    assign push_valid      = accept && (n != 2'd0);
    assign push_cmd.two    = (n == 2'd2);
    assign push_cmd.first  = r0;
    assign push_cmd.second = r1;
    assign stat.mode       = mode_reg;
    assign stat.push       = push_valid;

    // Lexer mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

### design/jbt_queue.sv
module jbt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  jbt_pkg::cmd_t push_cmd,
    output logic          push_ready,
    output logic          head_valid,
    output jbt_pkg::cmd_t head_cmd,
    input  logic          pop
);
    import jbt_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/jbt_back.sv
module jbt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  jbt_pkg::cmd_t head_cmd,
    output logic          pop,
    jbt_out_if.source     tokens
);
    import jbt_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    logic sel_reg;
    logic sel_next;
    res_t res_reg;
    res_t res_sel;
    logic load;

    // Load the output register when it is empty or being taken.
    assign load    = head_valid && (!out_valid_reg || tokens.ready);
    assign res_sel = sel_reg ? head_cmd.second : head_cmd.first;
    assign pop     = load && (sel_reg || !head_cmd.two);

    always_comb
    begin
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            sel_next       = head_cmd.two && !sel_reg;
            out_valid_next = 1'b1;
        end
        else if (tokens.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_sel;
        end
    end

    assign tokens.valid      = out_valid_reg;
    assign tokens.token_type = res_reg.token_type;
    assign tokens.has_char   = res_reg.has_char;
    assign tokens.char_value = res_reg.char_value;
    assign tokens.token_end  = res_reg.token_end;
    assign tokens.error      = res_reg.error;
    assign tokens.last       = res_reg.last;

endmodule

### design/json_byte_tokenizer.sv
// JSON byte tokenizer.
// The bytes channel takes one word per cycle: a text byte (kind 0) or an
// end-of-input mark (kind 1). The tokens channel gives token events: single
// punctuation tokens, one word per character of a string, number or keyword
// followed by a closing word with token_end set, and EOF at end of input.
// The last flag marks the final word caused by an input word.
// With the queue and output register empty, a result is written into the command
// queue when its input word is taken, then into the output register, and is valid from there.
// Input words are taken at one per cycle. An input word that causes two results keeps
// the output stage busy for both of them; a four-entry command queue between the
// classifier and the output stage absorbs such bursts, and the bytes channel drops
// ready only when that queue is full.
// When the tokens receiver stalls, the output register holds its word and the
// queue fills, after which bytes.ready goes low.
// Reset clears the lexer mode to between tokens and empties the queue.
// After an error word the block gives no further words until reset.
module json_byte_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    jbt_in_if.sink     bytes,
    jbt_out_if.source  tokens
);
    import jbt_pkg::*;

    logic        push_valid;
    logic        push_ready;
    cmd_t        push_cmd;
    logic        head_valid;
    cmd_t        head_cmd;
    logic        pop;
    front_stat_t stat;

    // Classifier with the lexer mode.
    jbt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .stat       (stat)
    );

    // Command queue between the two sides.
    jbt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    // Output stage.
    jbt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .tokens     (tokens)
    );

    // Checks.
`include "json_byte_tokenizer_assert.svh"

    `JBT_ASSERT_NOW(a_fail_silent, stat.mode == MODE_FAIL, !stat.push, "push while failed")
    `JBT_ASSERT_NOW(a_error_word, tokens.valid && tokens.error,
        tokens.last && !tokens.has_char && tokens.token_type == TT_EOF, "malformed error word")
    `JBT_ASSERT_NOW(a_char_zero, tokens.valid && !tokens.has_char,
        tokens.char_value == 8'd0, "stray character value")
    `JBT_ASSERT_NEXT(a_quiet_after_error, tokens.valid && tokens.ready && tokens.error,
        !tokens.valid, "word after error")

endmodule

### tb/sv/json_byte_tokenizer_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts the token words of every accepted input
// word and compares each accepted token word with the oldest prediction.
module json_byte_tokenizer_checker (
    input  logic clk,
    input  logic rst_n,
    jbt_in_if    bytes,
    jbt_out_if   tokens,
    output int   mismatches,
    output int   pending,
    output int   checked
);
    import jbt_pkg::*;

    // Lexer mode of the prediction and the token words still owed by the block.
    logic [2:0] lex_mode;
    res_t       expected_tokens[$];
    int         bad_fields;
    int         words_checked;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // Append one token word; the character is forced to zero when it carries none.
    function automatic void queue_token(input logic [3:0] tt, input logic has_ch,
                                        input logic [7:0] ch, input logic done,
                                        input logic err);
        res_t w;
        w.token_type = tt;
        w.has_char   = has_ch;
        w.char_value = has_ch ? ch : 8'h00;
        w.token_end  = done;
        w.error      = err;
        w.last       = 1'b0;
        expected_tokens.push_back(w);
    endfunction

    // A text byte seen between tokens.
    function automatic void start_token(input logic [7:0] c);
        case (c)
            "{": queue_token(TT_OBJ_OPEN, 1'b0, 8'h00, 1'b1, 1'b0);
            "}": queue_token(TT_OBJ_CLOSE, 1'b0, 8'h00, 1'b1, 1'b0);
            "[": queue_token(TT_ARR_OPEN, 1'b0, 8'h00, 1'b1, 1'b0);
            "]": queue_token(TT_ARR_CLOSE, 1'b0, 8'h00, 1'b1, 1'b0);
            ":": queue_token(TT_COLON, 1'b0, 8'h00, 1'b1, 1'b0);
            ",": queue_token(TT_COMMA, 1'b0, 8'h00, 1'b1, 1'b0);
            "\"": lex_mode = MODE_STR;
            // Tab through carriage return, and space, are skipped.
            8'd9, 8'd10, 8'd11, 8'd12, 8'd13, " ": ;
            default:
            begin
                if (is_digit(c))
                begin
                    lex_mode = MODE_NUM;
                    queue_token(TT_NUMBER, 1'b1, c, 1'b0, 1'b0);
                end
                else if (is_letter(c))
                begin
                    lex_mode = MODE_KEY;
                    queue_token(TT_KEYWORD, 1'b1, c, 1'b0, 1'b0);
                end
                else
                begin
                    lex_mode = MODE_FAIL;
                    queue_token(TT_EOF, 1'b0, 8'h00, 1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    // Predict the token words of one input word; eoi is the end-of-input kind.
    function automatic void lex_word(input logic eoi, input logic [7:0] c);
        int         n_prior;
        logic [3:0] run_type;
        res_t       tail;
        n_prior  = expected_tokens.size();
        run_type = (lex_mode == MODE_NUM) ? TT_NUMBER : TT_KEYWORD;
        case (lex_mode)
            MODE_STR, MODE_STR_ESC:
            begin
                if (eoi)
                begin
                    // An open string is closed, a pending escape is lost.
                    queue_token(TT_STRING, 1'b0, 8'h00, 1'b1, 1'b0);
                    queue_token(TT_EOF, 1'b0, 8'h00, 1'b1, 1'b0);
                    lex_mode = MODE_IDLE;
                end
                else if (lex_mode == MODE_STR_ESC)
                begin
                    queue_token(TT_STRING, 1'b1, c, 1'b0, 1'b0);
                    lex_mode = MODE_STR;
                end
                else if (c == "\"")
                begin
                    queue_token(TT_STRING, 1'b0, 8'h00, 1'b1, 1'b0);
                    lex_mode = MODE_IDLE;
                end
                else if (c == "\\")
                    lex_mode = MODE_STR_ESC;
                else
                    queue_token(TT_STRING, 1'b1, c, 1'b0, 1'b0);
            end
            MODE_NUM, MODE_KEY:
            begin
                if (!eoi && (lex_mode == MODE_NUM ? is_digit(c) : is_letter(c)))
                    queue_token(run_type, 1'b1, c, 1'b0, 1'b0);
                else
                begin
                    // Close the run, then treat the byte as if between tokens.
                    queue_token(run_type, 1'b0, 8'h00, 1'b1, 1'b0);
                    lex_mode = MODE_IDLE;
                    if (eoi)
                        queue_token(TT_EOF, 1'b0, 8'h00, 1'b1, 1'b0);
                    else
                        start_token(c);
                end
            end
            MODE_IDLE:
            begin
                if (eoi)
                    queue_token(TT_EOF, 1'b0, 8'h00, 1'b1, 1'b0);
                else
                    start_token(c);
            end
            default:
                lex_mode = MODE_FAIL;
        endcase

        // The final word caused by this input carries the last flag.
        if (expected_tokens.size() > n_prior)
        begin
            tail      = expected_tokens.pop_back();
            tail.last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: token field %s expected %0d, got %0d", $time, field, want, got);
            bad_fields++;
        end
    endfunction

    // Compare one accepted token word with the oldest prediction.
    function automatic void compare_token();
        res_t want;
        if (expected_tokens.size() == 0)
        begin
            $display("%0t: token word expected none, got type %0d char %0d last %0d",
                     $time, tokens.token_type, tokens.char_value, tokens.last);
            bad_fields++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            words_checked++;
            check_field("token_type", int'(want.token_type), int'(tokens.token_type));
            check_field("has_char", int'(want.has_char), int'(tokens.has_char));
            check_field("char_value", int'(want.char_value), int'(tokens.char_value));
            check_field("token_end", int'(want.token_end), int'(tokens.token_end));
            check_field("error", int'(want.error), int'(tokens.error));
            check_field("last", int'(want.last), int'(tokens.last));
        end
    endfunction

    // Token words pass through the command queue and the output register after their
    // input word is taken, so the compare may run before the prediction of the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode = MODE_IDLE;
            expected_tokens.delete();
            bad_fields    = 0;
            words_checked = 0;
        end
        else
        begin
            if (tokens.valid && tokens.ready)
                compare_token();
            if (bytes.valid && bytes.ready)
                lex_word(bytes.kind, bytes.data_byte);
        end
        mismatches <= bad_fields;
        pending    <= expected_tokens.size();
        checked    <= words_checked;
    end

endmodule

### tb/sv/json_byte_tokenizer_test.sv
`timescale 1ns / 100ps

module json_byte_tokenizer_test;

    localparam int   HALF_PERIOD     = 6;
    localparam int   RESET_CYCLES    = 9;
    localparam int   CYCLE_LIMIT     = 100000;
    localparam int   HOLD_OFF_CYCLES = 120;
    localparam int   DRAIN_CYCLES    = 20;
    localparam int   WORD_TARGET     = 1250;
    localparam logic KIND_BYTE       = 1'b0;
    localparam logic KIND_END        = 1'b1;

    logic clk;
    logic rst_n;
    bit   steady;
    bit   hold_off_req;
    int   words_sent;
    int   cycle_count;
    int   mismatches;
    int   pending;
    int   checked;

    jbt_in_if  byte_ch ();
    jbt_out_if token_ch ();

    json_byte_tokenizer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .tokens (token_ch)
    );

    json_byte_tokenizer_checker lex_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (byte_ch),
        .tokens     (token_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d token words outstanding",
                     cycle_count, pending);
            $display("json_byte_tokenizer_test failed");
            $finish;
        end
    end

    // Token receiver: random stalls, none in steady phases, one long hold-off.
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            token_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_off_req <= 1'b0;
        end
        else if (steady)
            token_ch.ready <= 1'b1;
        else
            token_ch.ready <= ($urandom_range(99) >= 30);
    end

    // Offer one input word and wait until it is taken; valid stays high after.
    task automatic send_word(input logic k, input logic [7:0] b);
        while (!steady && $urandom_range(99) < 30)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.kind      <= k;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // One random piece of JSON text; strings are sometimes cut off by an end mark.
    task automatic send_fragment();
        int         pick;
        int         len;
        int         cut;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            case ($urandom_range(5))
                0: ch = "{";
                1: ch = "}";
                2: ch = "[";
                3: ch = "]";
                4: ch = ":";
                default: ch = ",";
            endcase
            send_word(KIND_BYTE, ch);
        end
        else if (pick < 30)
        begin
            ch = ($urandom_range(5) == 0) ? " " : 8'(9 + $urandom_range(4));
            send_word(KIND_BYTE, ch);
        end
        else if (pick < 45)
        begin
            len = $urandom_range(1, 6);
            repeat (len)
            begin
                ch = 8'("0" + $urandom_range(9));
                send_word(KIND_BYTE, ch);
            end
        end
        else if (pick < 60)
        begin
            len = $urandom_range(1, 6);
            repeat (len)
            begin
                ch = 8'((($urandom_range(1) != 0) ? "a" : "A") + $urandom_range(25));
                send_word(KIND_BYTE, ch);
            end
        end
        else if (pick < 90)
        begin
            send_word(KIND_BYTE, "\"");
            len = $urandom_range(0, 8);
            repeat (len)
            begin
                if ($urandom_range(99) < 15)
                begin
                    send_word(KIND_BYTE, "\\");
                    ch = 8'($urandom_range(255));
                    send_word(KIND_BYTE, ch);
                end
                else
                begin
                    do
                        ch = 8'($urandom_range(255));
                    while (ch == "\"" || ch == "\\");
                    send_word(KIND_BYTE, ch);
                end
            end
            cut = $urandom_range(99);
            if (cut < 8)
                send_word(KIND_BYTE, "\\");
            if (cut < 16)
            begin
                ch = 8'($urandom_range(255));
                send_word(KIND_END, ch);
            end
            else
                send_word(KIND_BYTE, "\"");
        end
        else
        begin
            ch = 8'($urandom_range(255));
            send_word(KIND_END, ch);
        end
    endtask

    initial
    begin
        logic [7:0] bad_byte;
        logic [7:0] noise;
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.kind      = KIND_BYTE;
        byte_ch.data_byte = 8'h00;
        token_ch.ready    = 1'b0;
        steady            = 1'b0;
        hold_off_req      = 1'b0;
        words_sent        = 0;
        cycle_count       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text: skipped space, empty string, high byte and escaped
        // quote in a string, runs closed by punctuation, whitespace and end
        // marks, a bare end mark, and an end mark right after a backslash.
        send_word(KIND_BYTE, " ");
        send_word(KIND_BYTE, "{");
        send_word(KIND_BYTE, "\"");
        send_word(KIND_BYTE, "\"");
        send_word(KIND_BYTE, ":");
        send_word(KIND_BYTE, "\"");
        send_word(KIND_BYTE, 8'hFF);
        send_word(KIND_BYTE, "\\");
        send_word(KIND_BYTE, "\"");
        send_word(KIND_BYTE, "\"");
        send_word(KIND_BYTE, ",");
        send_word(KIND_BYTE, "0");
        send_word(KIND_BYTE, "9");
        send_word(KIND_BYTE, "]");
        send_word(KIND_BYTE, "[");
        send_word(KIND_BYTE, "A");
        send_word(KIND_BYTE, "z");
        send_word(KIND_BYTE, 8'd9);
        send_word(KIND_BYTE, "Z");
        send_word(KIND_END, 8'hA5);
        send_word(KIND_END, 8'h00);
        send_word(KIND_BYTE, "\"");
        send_word(KIND_BYTE, "\\");
        send_word(KIND_END, 8'hFF);
        send_word(KIND_BYTE, "}");

        // Random text with idling on both sides.
        while (words_sent < 500)
            send_fragment();

        // Steady phase; it opens with the receiver held off so the block backs up.
        steady       <= 1'b1;
        hold_off_req <= 1'b1;
        while (words_sent < 800)
            send_fragment();

        steady <= 1'b0;
        while (words_sent < WORD_TARGET - 10)
            send_fragment();

        // A byte that cannot start a token, then input the block must ignore.
        case ($urandom_range(3))
            0: bad_byte = "!";
            1: bad_byte = "\\";
            2: bad_byte = "-";
            default: bad_byte = 8'($urandom_range(128, 255));
        endcase
        send_word(KIND_BYTE, bad_byte);
        repeat (8)
        begin
            noise = 8'($urandom_range(255));
            send_word(1'($urandom_range(1)), noise);
        end
        byte_ch.valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d input words, %0d token words compared, %0d field mismatches.",
                 words_sent, checked, mismatches);
        $display("Covered directed corners, random text with escapes and cut strings, %0d %s",
                 HOLD_OFF_CYCLES, "cycles of receiver hold-off, and ignored input after an error.");
        if (mismatches == 0 && pending == 0)
            $display("json_byte_tokenizer_test passed");
        else
            $display("json_byte_tokenizer_test failed");
        $finish;
    end

endmodule
